FILE: hdl/ahdf_pkg.sv
// Shared types, codes and the FCS-16 step for the async HDLC deframer.
// No dependencies; imported by ahdf_cfg_regs and async_hdlc_deframer_fcs16.
`timescale 1ns / 1ps
`default_nettype none

package ahdf_pkg;

  // Line control bytes
  localparam logic [7:0] FLAG_BYTE = 8'h7e;
  localparam logic [7:0] ESC_BYTE  = 8'h7d;
  localparam logic [7:0] ESC_XOR   = 8'h20;

  // FCS-16, reflected polynomial
  localparam logic [15:0] FCS_INIT = 16'hffff;
  localparam logic [15:0] FCS_GOOD = 16'hf0b8;
  localparam logic [15:0] FCS_POLY = 16'h8408;

  // Configuration space
  localparam int unsigned CFG_ADDR_W      = 3;
  localparam int unsigned CFG_DATA_W      = 32;
  localparam logic        REG_MAX_FRAME   = 1'b0;
  localparam logic [15:0] MAX_FRAME_RESET = 16'd2048;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_DATA     = 3'd0,
    KIND_GOOD     = 3'd1,
    KIND_BADFCS   = 3'd2,
    KIND_OVERFLOW = 3'd3,
    KIND_ABORT    = 3'd4
  } kind_e;

  // Receive mode, one-hot
  typedef enum logic [2:0] {
    MODE_HUNT  = 3'b001,
    MODE_FRAME = 3'b010,
    MODE_ESC   = 3'b100
  } mode_e;

  // Fold one data byte into the running FCS, one bit per step
  function automatic logic [15:0] fcs16_step(input logic [15:0] fcs, input logic [7:0] data);
    logic [15:0] f;
    f = fcs ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      f = f[0] ? ((f >> 1) ^ FCS_POLY) : (f >> 1);
    end
    return f;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/ahdf_cfg_regs.sv
// APB-style configuration register for the deframer (max_frame_bytes).
// Depends on ahdf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ahdf_cfg_regs (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [ahdf_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [ahdf_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [ahdf_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                  pready,
  output logic      [15:0]                      max_frame_bytes_o
);
  import ahdf_pkg::*;

  logic        reg_idx;
  logic        wr_en;
  logic [15:0] max_frame_q;
  logic [15:0] max_frame_d;

  // Decode register index from the word address
  assign reg_idx = paddr[2];
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready & (reg_idx == REG_MAX_FRAME);

  // Capture the limit on a completed write request
  always_comb begin
    max_frame_d = max_frame_q;
    if (wr_en) begin
      max_frame_d = pwdata[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_frame_q <= MAX_FRAME_RESET;
    end else begin
      max_frame_q <= max_frame_d;
    end
  end

  // Return the register on reads, zero elsewhere
  always_comb begin
    prdata = '0;
    if (reg_idx == REG_MAX_FRAME) begin
      prdata = {{(CFG_DATA_W-16){1'b0}}, max_frame_q};
    end
  end

  assign max_frame_bytes_o = max_frame_q;

endmodule

`default_nettype wire

FILE: hdl/async_hdlc_deframer_fcs16.sv
// Async HDLC receive deframer with FCS-16 check: top level.
// Depends on ahdf_pkg and ahdf_cfg_regs.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-------------------------------------------
//   in       | in_valid_i / in_stall_o    | rx_byte_i
//   out      | out_valid_o / out_stall_i  | out_byte_o, result_kind_o, frame_length_o
//   cfg      | psel, penable, pwrite      | paddr, pwdata, prdata, pready
//
// One received byte per cycle sustained while out_stall_i is low. A byte is
// registered in the input register; the mode/delay/FCS update and the result
// register load happen when it advances, so a result passes through the input register and then the result register.
// Reset leaves the block hunting for a flag with the limit at 2048 bytes.
// in_stall_o rises only while a byte waits and the result register is held
// by out_stall_i.
`timescale 1ns / 1ps
`default_nettype none

module async_hdlc_deframer_fcs16 #(
  parameter int unsigned LENGTH_WIDTH = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Line byte input
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [7:0]                       rx_byte_i,
  // Result output
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic      [7:0]                       out_byte_o,
  output logic      [2:0]                       result_kind_o,
  output logic      [15:0]                      frame_length_o,
  // Configuration
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [ahdf_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [ahdf_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [ahdf_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                  pready
);
  import ahdf_pkg::*;

  // Compare width covers both the count and the 16-bit limit
  localparam int unsigned CW = (LENGTH_WIDTH > 16) ? LENGTH_WIDTH : 16;

  logic [15:0] max_frame_bytes;

  ahdf_cfg_regs u_cfg (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .max_frame_bytes_o (max_frame_bytes)
  );

  // ------------------------------------------------------------------
  // Input register
  // ------------------------------------------------------------------
  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q, in_byte_d;
  logic       in_take;
  logic       out_free;
  logic       advance;

  assign out_free   = ~out_valid_o | ~out_stall_i;
  assign advance    = in_vld_q & out_free;
  assign in_stall_o = in_vld_q & ~out_free;
  assign in_take    = in_valid_i & ~in_stall_o;

  always_comb begin
    in_vld_d  = in_vld_q;
    in_byte_d = in_byte_q;
    if (in_take) begin
      in_vld_d  = 1'b1;
      in_byte_d = rx_byte_i;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  // ------------------------------------------------------------------
  // Deframer state
  // ------------------------------------------------------------------
  mode_e                   mode_q, mode_d;
  logic [1:0]              seen_q, seen_d;
  logic [LENGTH_WIDTH-1:0] count_q, count_d;
  logic [15:0]             fcs_q, fcs_d;
  logic [7:0]              held_old_q, held_old_d;
  logic [7:0]              held_new_q, held_new_d;

  logic          res_vld;
  logic [7:0]    res_byte;
  kind_e         res_kind;
  logic [15:0]   res_len;

  logic [CW-1:0] count_ext;
  logic [CW-1:0] max_ext;
  logic [CW-1:0] len_mask_ext;
  logic [CW-1:0] limit_ext;
  logic          is_flag;
  logic          is_esc;
  logic [7:0]    data_byte;
  logic          take_data;
  logic          do_open;

  // Effective limit: register capped at the counter's range
  assign count_ext    = CW'(count_q);
  assign max_ext      = CW'(max_frame_bytes);
  assign len_mask_ext = CW'({LENGTH_WIDTH{1'b1}});
  assign limit_ext    = (max_ext > len_mask_ext) ? len_mask_ext : max_ext;

  assign is_flag   = (in_byte_q == FLAG_BYTE);
  assign is_esc    = (in_byte_q == ESC_BYTE);
  assign data_byte = (mode_q == MODE_ESC) ? (in_byte_q ^ ESC_XOR) : in_byte_q;

  // Classify the byte against the current mode
  always_comb begin
    take_data = 1'b0;
    do_open   = 1'b0;
    case (mode_q)
      MODE_FRAME: begin
        do_open   = is_flag;
        take_data = ~is_flag & ~is_esc;
      end
      MODE_ESC: begin
        do_open   = is_flag;
        take_data = ~is_flag;
      end
      default: begin
        do_open = is_flag;
      end
    endcase
  end

  // Next state and result for the byte in the input register
  always_comb begin
    mode_d     = mode_q;
    seen_d     = seen_q;
    count_d    = count_q;
    fcs_d      = fcs_q;
    held_old_d = held_old_q;
    held_new_d = held_new_q;
    res_vld    = 1'b0;
    res_byte   = '0;
    res_kind   = KIND_DATA;
    res_len    = '0;

    if (do_open) begin
      // Close the frame, report it if payload went out, open the next one
      if ((mode_q != MODE_HUNT) && (count_q != '0)) begin
        res_vld  = 1'b1;
        res_len  = count_ext[15:0];
        if (mode_q == MODE_ESC) begin
          res_kind = KIND_ABORT;
        end else if (fcs_q == FCS_GOOD) begin
          res_kind = KIND_GOOD;
        end else begin
          res_kind = KIND_BADFCS;
        end
      end
      mode_d     = MODE_FRAME;
      seen_d     = 2'd0;
      count_d    = '0;
      fcs_d      = FCS_INIT;
      held_old_d = '0;
      held_new_d = '0;
    end else if (take_data) begin
      if (seen_q[1] && (count_ext >= limit_ext)) begin
        // Overflow: drop the byte and go hunting
        res_vld  = 1'b1;
        res_kind = KIND_OVERFLOW;
        res_len  = count_ext[15:0];
        mode_d   = MODE_HUNT;
      end else begin
        // Push out the oldest held byte once the delay is full
        if (seen_q[1]) begin
          res_vld  = 1'b1;
          res_byte = held_old_q;
          count_d  = count_q + LENGTH_WIDTH'(1);
        end
        held_old_d = held_new_q;
        held_new_d = data_byte;
        if (!seen_q[1]) begin
          seen_d = seen_q + 2'd1;
        end
        fcs_d  = fcs16_step(fcs_q, data_byte);
        mode_d = MODE_FRAME;
      end
    end else if (mode_q == MODE_FRAME) begin
      // Escape byte: hold state, mark the next byte
      mode_d = MODE_ESC;
    end else begin
      mode_d = MODE_HUNT;
    end
  end

  // ------------------------------------------------------------------
  // Result register
  // ------------------------------------------------------------------
  logic        out_vld_q, out_vld_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic [2:0]  out_kind_q, out_kind_d;
  logic [15:0] out_len_q, out_len_d;
  logic        load_res;

  assign load_res = advance & res_vld;

  always_comb begin
    out_vld_d  = out_vld_q;
    out_byte_d = out_byte_q;
    out_kind_d = out_kind_q;
    out_len_d  = out_len_q;
    if (load_res) begin
      out_vld_d  = 1'b1;
      out_byte_d = res_byte;
      out_kind_d = res_kind;
      out_len_d  = res_len;
    end else if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      mode_q    <= MODE_HUNT;
      seen_q    <= 2'd0;
      count_q   <= '0;
      fcs_q     <= FCS_INIT;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (advance) begin
        mode_q  <= mode_d;
        seen_q  <= seen_d;
        count_q <= count_d;
        fcs_q   <= fcs_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    in_byte_q  <= in_byte_d;
    out_byte_q <= out_byte_d;
    out_kind_q <= out_kind_d;
    out_len_q  <= out_len_d;
    if (advance) begin
      held_old_q <= held_old_d;
      held_new_q <= held_new_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign out_byte_o     = out_byte_q;
  assign result_kind_o  = out_kind_q;
  assign frame_length_o = out_len_q;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  // No payload can have left before the delay line filled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seen_q[1] |-> (count_q == '0))
    else $error("payload counted before delay line full");

  // A result computed on an advancing byte shows up on the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_vld) |=> out_valid_o)
    else $error("computed result not presented");

  // Input stalls only when a result is held by the downstream side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && in_vld_q))
    else $error("input stalled without output backpressure");

endmodule

`default_nettype wire
